FILE: rtl/core/gada_pkg.sv
// ----------------------------------------------------------------------------
// gada_pkg
// Shared types, constants and the month length table for the date adder.
// ----------------------------------------------------------------------------
package gada_pkg;

  localparam int unsigned DAY_W   = 5;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned ADD_W   = 12;
  localparam int unsigned REM_W   = 13;
  localparam int unsigned Q400_W  = 6;
  localparam int unsigned Q100_W  = 8;
  localparam int unsigned R400_W  = 9;
  localparam int unsigned R100_W  = 7;
  localparam int unsigned UPC_W   = 3;
  localparam int unsigned STEPS   = 8;

  localparam logic [13:0] Q400_MUL   = 14'd10486;
  localparam logic [15:0] Q100_MUL   = 16'd41944;
  localparam logic [13:0] YEAR_400   = 14'd400;
  localparam logic [13:0] YEAR_100   = 14'd100;
  localparam logic [R400_W-1:0] R400_LAST = 9'd399;
  localparam logic [R100_W-1:0] R100_LAST = 7'd99;
  localparam logic [YEAR_W-1:0] YEAR_LAST = 14'h3fff;

  localparam logic [MONTH_W-1:0] JAN = 4'd1;
  localparam logic [MONTH_W-1:0] FEB = 4'd2;
  localparam logic [MONTH_W-1:0] DEC = 4'd12;
  localparam logic [DAY_W-1:0]   FEB_LEAP_DAYS = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  localparam logic [UPC_W-1:0] STEP_IDLE = 3'd0;
  localparam logic [UPC_W-1:0] STEP_ACC  = 3'd3;
  localparam logic [UPC_W-1:0] STEP_SUB  = 3'd5;
  localparam logic [UPC_W-1:0] STEP_OUT  = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_MOD1,
    OP_MOD2,
    OP_ACC,
    OP_ADD,
    OP_SUB,
    OP_OUT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEXT,
    COND_ALWAYS,
    COND_NO_START,
    COND_ACC_MORE,
    COND_SUB_MORE,
    COND_OUT_BLOCKED
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [UPC_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic acc_more;
    logic sub_more;
    logic out_blocked;
  } dp_status_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    logic [MONTH_W-1:0] idx;
    idx = m - JAN;
    if ((m < JAN) || (m > DEC)) begin
      month_len = '0;
    end else if ((m == FEB) && leap) begin
      month_len = FEB_LEAP_DAYS;
    end else begin
      month_len = MONTH_LEN[idx];
    end
  endfunction

endpackage

FILE: rtl/core/gada_urom.sv
// ----------------------------------------------------------------------------
// gada_urom
// Control store: one control word per step of the date adder program.
// ----------------------------------------------------------------------------
module gada_urom (
  input  logic [gada_pkg::UPC_W-1:0] upc_i,
  output gada_pkg::ctrl_t            ctrl_o
);
  import gada_pkg::*;

  localparam ctrl_t PROGRAM [STEPS] = '{
    '{op: OP_NOP,  cond: COND_NO_START,    target: STEP_IDLE},
    '{op: OP_MOD1, cond: COND_NEXT,        target: STEP_IDLE},
    '{op: OP_MOD2, cond: COND_NEXT,        target: STEP_IDLE},
    '{op: OP_ACC,  cond: COND_ACC_MORE,    target: STEP_ACC},
    '{op: OP_ADD,  cond: COND_NEXT,        target: STEP_IDLE},
    '{op: OP_SUB,  cond: COND_SUB_MORE,    target: STEP_SUB},
    '{op: OP_OUT,  cond: COND_OUT_BLOCKED, target: STEP_OUT},
    '{op: OP_NOP,  cond: COND_ALWAYS,      target: STEP_IDLE}
  };

  assign ctrl_o = PROGRAM[upc_i];

endmodule

FILE: rtl/core/gada_seq.sv
// ----------------------------------------------------------------------------
// gada_seq
// Step counter with conditional jumps driven by the current control word.
// ----------------------------------------------------------------------------
module gada_seq (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  gada_pkg::ctrl_t            ctrl_i,
  input  gada_pkg::dp_status_t       status_i,
  output logic [gada_pkg::UPC_W-1:0] upc_o
);
  import gada_pkg::*;

  logic [UPC_W-1:0] upc_q, upc_d;
  logic             take_jump;

  always_comb begin
    unique case (ctrl_i.cond)
      COND_NEXT:        take_jump = 1'b0;
      COND_ALWAYS:      take_jump = 1'b1;
      COND_NO_START:    take_jump = !start_i;
      COND_ACC_MORE:    take_jump = status_i.acc_more;
      COND_SUB_MORE:    take_jump = status_i.sub_more;
      COND_OUT_BLOCKED: take_jump = status_i.out_blocked;
      default:          take_jump = 1'b1;
    endcase
    upc_d = take_jump ? ctrl_i.target : upc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= STEP_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign upc_o = upc_q;

  a_idle_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == STEP_IDLE && !start_i) |=> (upc_q == STEP_IDLE))
    else $error("sequencer left idle without a word");

endmodule

FILE: rtl/core/gada_dp.sv
// ----------------------------------------------------------------------------
// gada_dp
// Datapath: ordinal day accumulator, month walker, year residues and the
// output register.
// ----------------------------------------------------------------------------
module gada_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [gada_pkg::DAY_W-1:0]   start_day_i,
  input  logic [gada_pkg::MONTH_W-1:0] start_month_i,
  input  logic [gada_pkg::YEAR_W-1:0]  start_year_i,
  input  logic [gada_pkg::ADD_W-1:0]   days_to_add_i,
  input  gada_pkg::ctrl_t              ctrl_i,
  output gada_pkg::dp_status_t         status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [gada_pkg::DAY_W-1:0]   end_day_o,
  output logic [gada_pkg::MONTH_W-1:0] end_month_o,
  output logic [gada_pkg::YEAR_W-1:0]  end_year_o
);
  import gada_pkg::*;

  logic [DAY_W-1:0]   day_q;
  logic [MONTH_W-1:0] month_q;
  logic [ADD_W-1:0]   add_q;
  logic [YEAR_W-1:0]  y_q;
  logic [MONTH_W-1:0] cnt_q;
  logic [REM_W-1:0]   rem_q;
  logic [Q400_W-1:0]  q400_q;
  logic [Q100_W-1:0]  q100_q;
  logic [R400_W-1:0]  r400_q;
  logic [R100_W-1:0]  r100_q;
  logic               out_valid_q;
  logic [DAY_W-1:0]   end_day_q;
  logic [MONTH_W-1:0] end_month_q;
  logic [YEAR_W-1:0]  end_year_q;

  logic               leap;
  logic [DAY_W-1:0]   dim;
  logic [REM_W-1:0]   dim_ext;
  logic [27:0]        prod400;
  logic [29:0]        prod100;
  logic [YEAR_W-1:0]  sub400;
  logic [YEAR_W-1:0]  sub100;
  logic               acc_more;
  logic               sub_more;
  logic               out_blocked;

  always_comb begin
    leap     = (r400_q == '0) || ((r100_q != '0) && (y_q[1:0] == 2'b00));
    dim      = month_len(cnt_q, leap);
    dim_ext  = REM_W'(dim);
    prod400  = {14'b0, y_q} * {14'b0, Q400_MUL};
    prod100  = {16'b0, y_q} * {14'b0, Q100_MUL};
    sub400   = y_q - YEAR_W'({8'b0, q400_q} * YEAR_400);
    sub100   = y_q - YEAR_W'({6'b0, q100_q} * YEAR_100);
    acc_more = (cnt_q < month_q) && (cnt_q <= DEC);
    sub_more = dim_ext < rem_q;
    out_blocked = out_valid_q && !out_ready_i;
  end

  assign status_o = '{acc_more: acc_more, sub_more: sub_more, out_blocked: out_blocked};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      day_q   <= start_day_i;
      month_q <= start_month_i;
      add_q   <= days_to_add_i;
      y_q     <= start_year_i;
      cnt_q   <= JAN;
      rem_q   <= '0;
    end else begin
      unique case (ctrl_i.op)
        OP_MOD1: begin
          q400_q <= prod400[27:22];
          q100_q <= prod100[29:22];
        end
        OP_MOD2: begin
          r400_q <= sub400[R400_W-1:0];
          r100_q <= sub100[R100_W-1:0];
        end
        OP_ACC: begin
          if (acc_more) begin
            rem_q <= rem_q + dim_ext;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        OP_ADD: begin
          rem_q <= rem_q + REM_W'(day_q) + REM_W'(add_q);
          cnt_q <= JAN;
        end
        OP_SUB: begin
          if (sub_more) begin
            rem_q <= rem_q - dim_ext;
            if (cnt_q == DEC) begin
              cnt_q <= JAN;
              y_q   <= y_q + 1'b1;
              // residues restart when the year wraps around
              if (y_q == YEAR_LAST) begin
                r400_q <= '0;
                r100_q <= '0;
              end else begin
                r400_q <= (r400_q == R400_LAST) ? '0 : r400_q + 1'b1;
                r100_q <= (r100_q == R100_LAST) ? '0 : r100_q + 1'b1;
              end
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        OP_NOP, OP_OUT: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if ((ctrl_i.op == OP_OUT) && !out_blocked) begin
      end_day_q   <= rem_q[DAY_W-1:0];
      end_month_q <= cnt_q;
      end_year_q  <= y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((ctrl_i.op == OP_OUT) && !out_blocked) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign end_day_o   = end_day_q;
  assign end_month_o = end_month_q;
  assign end_year_o  = end_year_q;

  a_sub_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_SUB) |-> (cnt_q >= JAN && cnt_q <= DEC))
    else $error("month walker out of range");

  a_residue_mod4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == OP_SUB) |-> (r400_q[1:0] == y_q[1:0]))
    else $error("year residue out of step with year");

  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(ctrl_i.op == OP_OUT))
    else $error("result shown without output step");

endmodule

FILE: rtl/core/gregorian_add_days_to_date_top.sv
// ----------------------------------------------------------------------------
// gregorian_add_days_to_date_top
// Adds a day count to a Gregorian date and returns the resulting date.
// ----------------------------------------------------------------------------
// One word is taken at a time and gives one result word. The control program
// first sums the months before the start month (at most 12), then walks the
// whole months from January of the start year, one month per cycle in the
// subtract loop of the control program. The output step waits while the
// output register still holds a result that has not been taken. A finished
// result sits in the output register while the next word is already accepted
// and worked on.
module gregorian_add_days_to_date_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_day, start_month, start_year, days_to_add, zero pad
  input  logic [39:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // end_day, end_month, end_year, zero pad
  output logic [23:0] m_tdata
);
  import gada_pkg::*;

  logic               start;
  logic [UPC_W-1:0]   upc;
  ctrl_t              ctrl;
  dp_status_t         status;
  logic [DAY_W-1:0]   end_day;
  logic [MONTH_W-1:0] end_month;
  logic [YEAR_W-1:0]  end_year;

  assign s_tready = (upc == STEP_IDLE);
  assign start    = s_tvalid && s_tready;

  gada_urom u_urom (
    .upc_i  (upc),
    .ctrl_o (ctrl)
  );

  gada_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .ctrl_i   (ctrl),
    .status_i (status),
    .upc_o    (upc)
  );

  gada_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .start_day_i   (s_tdata[4:0]),
    .start_month_i (s_tdata[8:5]),
    .start_year_i  (s_tdata[22:9]),
    .days_to_add_i (s_tdata[34:23]),
    .ctrl_i        (ctrl),
    .status_o      (status),
    .out_ready_i   (m_tready),
    .out_valid_o   (m_tvalid),
    .end_day_o     (end_day),
    .end_month_o   (end_month),
    .end_year_o    (end_year)
  );

  assign m_tdata = {1'b0, end_year, end_month, end_day};

endmodule

FILE: tb/sv/gregorian_add_days_to_date_top_tb.sv
// ----------------------------------------------------------------------------
// gregorian_add_days_to_date_top_tb
// Sends dates and day counts into the date adder and checks each result word
// against a behavioral calendar walk, or against the typed expected date for
// typed table rows. A short table of edge cases comes first, then random
// valid dates mixed with raw field noise. Both sides of the stream idle at
// random, and the run includes one long output stall and one full drain.
// ----------------------------------------------------------------------------
module gregorian_add_days_to_date_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gada_pkg::*;

  localparam int N_RANDOM     = 1100;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 200;
  localparam int STALL_LIMIT  = 4000;
  localparam int N_DIRECTED   = 22;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [ADD_W-1:0]   add;
    logic               typed;
    date_t              want;
  } dir_row_t;

  logic        clk_i    = 1'b0;
  logic        rst_ni   = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  date_t pending_dates [$];
  int    n_sent     = 0;
  int    n_checked  = 0;
  int    n_err      = 0;
  int    stall_cnt  = 0;
  bit    calm       = 1'b0;
  bit    hold_rx    = 1'b0;
  bit    hold_done  = 1'b0;

  // rows: day, month, year, days added, typed, expected date
  dir_row_t dir_tab [N_DIRECTED] = '{
    '{5'd1,  4'd1,  14'd1,     12'd0,    1'b1, '{5'd1,  4'd1, 14'd1}},
    '{5'd31, 4'd12, 14'd9999,  12'd1,    1'b1, '{5'd1,  4'd1, 14'd10000}},
    '{5'd0,  4'd0,  14'd2000,  12'd0,    1'b1, '{5'd0,  4'd1, 14'd2000}},
    '{5'd0,  4'd1,  14'd1999,  12'd0,    1'b1, '{5'd0,  4'd1, 14'd1999}},
    '{5'd31, 4'd0,  14'd2001,  12'd0,    1'b1, '{5'd31, 4'd1, 14'd2001}},
    '{5'd28, 4'd2,  14'd2000,  12'd1,    1'b1, '{5'd29, 4'd2, 14'd2000}},
    '{5'd28, 4'd2,  14'd1900,  12'd1,    1'b1, '{5'd1,  4'd3, 14'd1900}},
    '{5'd28, 4'd2,  14'd2024,  12'd1,    1'b1, '{5'd29, 4'd2, 14'd2024}},
    '{5'd28, 4'd2,  14'd0,     12'd1,    1'b1, '{5'd29, 4'd2, 14'd0}},
    '{5'd29, 4'd2,  14'd2100,  12'd0,    1'b1, '{5'd1,  4'd3, 14'd2100}},
    '{5'd31, 4'd2,  14'd2001,  12'd0,    1'b1, '{5'd3,  4'd3, 14'd2001}},
    '{5'd31, 4'd1,  14'd2023,  12'd29,   1'b1, '{5'd1,  4'd3, 14'd2023}},
    '{5'd1,  4'd13, 14'd2001,  12'd0,    1'b1, '{5'd1,  4'd1, 14'd2002}},
    '{5'd31, 4'd15, 14'd0,     12'd0,    1'b1, '{5'd31, 4'd1, 14'd1}},
    '{5'd31, 4'd12, 14'd16383, 12'd1,    1'b1, '{5'd1,  4'd1, 14'd0}},
    '{5'd31, 4'd15, 14'd16383, 12'd4095, 1'b0, '0},
    '{5'd1,  4'd1,  14'd2000,  12'd4095, 1'b0, '0},
    '{5'd1,  4'd1,  14'd1,     12'd4095, 1'b0, '0},
    '{5'd1,  4'd3,  14'd1600,  12'd365,  1'b0, '0},
    '{5'd31, 4'd12, 14'd9999,  12'd4095, 1'b0, '0},
    '{5'd15, 4'd7,  14'd2345,  12'd1000, 1'b0, '0},
    '{5'd30, 4'd4,  14'd1,     12'd2730, 1'b0, '0}
  };

  gregorian_add_days_to_date_top DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  function automatic bit is_leap_year(input int unsigned yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned yr, input int unsigned mo);
    case (mo)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(yr) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  // ordinal day in the start year plus the count, then walk months from january
  function automatic date_t date_after(input logic [DAY_W-1:0] d, input logic [MONTH_W-1:0] m,
                                       input logic [YEAR_W-1:0] y, input logic [ADD_W-1:0] n);
    int unsigned rem;
    int unsigned mo;
    int unsigned yr;
    date_t res;
    rem = 0;
    for (mo = 1; (mo < 32'(m)) && (mo <= 12); mo++) begin
      rem += month_days(32'(y), mo);
    end
    rem += 32'(d) + 32'(n);
    mo = 1;
    yr = 32'(y);
    while (month_days(yr, mo) < rem) begin
      rem -= month_days(yr, mo);
      mo++;
      if (mo > 12) begin
        mo = 1;
        yr++;
      end
    end
    res.day   = rem[DAY_W-1:0];
    res.month = mo[MONTH_W-1:0];
    res.year  = yr[YEAR_W-1:0];
    return res;
  endfunction

  function automatic logic [39:0] pack_word(input logic [DAY_W-1:0] d,
                                            input logic [MONTH_W-1:0] m,
                                            input logic [YEAR_W-1:0] y,
                                            input logic [ADD_W-1:0] n);
    return {5'b0, n, y, m, d};
  endfunction

  task automatic offer(input logic [39:0] w, input date_t want);
    while (!calm && ($urandom_range(99) < 10)) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= w;
    do @(posedge clk_i); while (!s_tready);
    pending_dates.push_back(want);
    n_sent++;
  endtask

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // receiver: random back-pressure, one long hold-off
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_rx && !hold_done) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end
      m_tready <= (calm || !rst_ni) ? rst_ni : ($urandom_range(99) >= 10);
    end
  end

  always @(posedge clk_i) begin
    date_t got;
    date_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.day   = m_tdata[4:0];
      got.month = m_tdata[8:5];
      got.year  = m_tdata[22:9];
      if (pending_dates.size() == 0) begin
        $display("%0t: unexpected result word %0d/%0d/%0d", $time,
                 got.day, got.month, got.year);
        n_err++;
      end else begin
        want = pending_dates.pop_front();
        n_checked++;
        if ((got.day !== want.day) || (got.month !== want.month) ||
            (got.year !== want.year)) begin
          $display("%0t: mismatch day/month/year expected %0d/%0d/%0d actual %0d/%0d/%0d",
                   $time, want.day, want.month, want.year, got.day, got.month, got.year);
          n_err++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cnt = 0;
    end else begin
      stall_cnt++;
    end
    if (stall_cnt >= STALL_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("gregorian_add_days_to_date_top_tb: FAIL");
      $finish;
    end
  end

  initial begin
    logic [DAY_W-1:0]   d;
    logic [MONTH_W-1:0] mo;
    logic [YEAR_W-1:0]  yr;
    logic [ADD_W-1:0]   n;
    int                 pick;
    wait (rst_ni);
    @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++) begin
      offer(pack_word(dir_tab[i].day, dir_tab[i].month, dir_tab[i].year, dir_tab[i].add),
            dir_tab[i].typed ? dir_tab[i].want :
            date_after(dir_tab[i].day, dir_tab[i].month, dir_tab[i].year, dir_tab[i].add));
    end
    for (int k = 0; k < N_RANDOM; k++) begin
      if (k == 300) hold_rx = 1'b1;
      calm = (k >= 450) && (k < 650);
      if (k == 800) begin
        s_tvalid <= 1'b0;
        do @(posedge clk_i); while (pending_dates.size() != 0);
      end
      if ($urandom_range(99) < 80) begin
        mo = MONTH_W'($urandom_range(12, 1));
        yr = YEAR_W'($urandom_range(9999, 1));
        d  = DAY_W'($urandom_range(month_days(32'(yr), 32'(mo)), 1));
        pick = $urandom_range(99);
        if (pick < 60) n = ADD_W'($urandom_range(4095, 0));
        else if (pick < 85) n = ADD_W'($urandom_range(60, 0));
        else n = ADD_W'($urandom_range(400, 0));
      end else begin
        d  = DAY_W'($urandom);
        mo = MONTH_W'($urandom);
        yr = YEAR_W'($urandom);
        n  = ADD_W'($urandom);
      end
      offer(pack_word(d, mo, yr, n), date_after(d, mo, yr, n));
    end
    s_tvalid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("sent %0d words (%0d table rows, %0d random), checked %0d results, %0d errors",
             n_sent, N_DIRECTED, N_RANDOM, n_checked, n_err);
    $display("covered leap rules, odd months and days, year wrap, long output stall, drain");
    if (n_err == 0) begin
      $display("gregorian_add_days_to_date_top_tb: PASS");
    end else begin
      $display("gregorian_add_days_to_date_top_tb: FAIL");
    end
    $finish;
  end

endmodule
